// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the multichannel stereo downmix.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

	typedef struct packed {
		logic             restart;
		logic             load_left;
		logic             load_right;
		logic             clear_sum;
		logic             add_rest;
		logic             load_mono;
		logic             load_pass;
		logic             div_load;
		logic             div_step;
		logic             mean_calc;
		logic             load_mix;
		logic [CNT_W-1:0] divisor;
	} msd_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/msd_if.sv =====
// ----------------------------------------------------------------------------
// msd_if
// Stream interfaces: sample input and stereo pair output.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_sample_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface msd_pair_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_out;
	logic signed [SAMPLE_WIDTH-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/msd_ctrl.sv =====
// ----------------------------------------------------------------------------
// msd_ctrl
// Controller: channel count register, frame position, divide sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_ctrl #(
	parameter int MAX_CHANNELS = 8,
	parameter int SUM_W        = 27
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [msd_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire                         in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire                         out_ready,
	output msd_pkg::msd_cmd_t           cmd
);
	import msd_pkg::*;

	localparam int POS_W  = $clog2(MAX_CHANNELS);
	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [CNT_W:0]    MAX_C     = (CNT_W+1)'(MAX_CHANNELS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	typedef enum logic [4:0] {
		ST_ACCUM = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_MEAN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    eff;
	logic [CNT_W:0]    pos_ext;
	logic [CNT_W:0]    pos_cur;
	logic              is_last;
	logic              accept;
	logic              set_out;

	always_comb begin
		if (cnt_q == '0) begin
			eff = (CNT_W+1)'(1);
		end else if ({1'b0, cnt_q} > MAX_C) begin
			eff = MAX_C;
		end else begin
			eff = {1'b0, cnt_q};
		end
	end

	assign pos_ext = (CNT_W+1)'(pos_q);
	assign pos_cur = (pos_ext >= eff) ? '0 : pos_ext;
	assign is_last = (pos_cur == eff - (CNT_W+1)'(1));
	assign in_ready = (state_q == ST_ACCUM) && !(is_last && out_valid);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.divisor = CNT_W'(eff - (CNT_W+1)'(2));
		cmd.restart = cfg_we;
		state_d = state_q;
		set_out = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				if (accept) begin
					if (eff == (CNT_W+1)'(1)) begin
						cmd.load_mono = 1'b1;
						set_out = 1'b1;
					end else begin
						if (pos_cur == '0) begin
							cmd.load_left = 1'b1;
							cmd.clear_sum = 1'b1;
						end else if (pos_cur == (CNT_W+1)'(1)) begin
							cmd.load_right = 1'b1;
						end else begin
							cmd.add_rest = 1'b1;
						end
						if (is_last) begin
							if (eff == (CNT_W+1)'(2)) begin
								cmd.load_pass = 1'b1;
								set_out = 1'b1;
							end else begin
								state_d = ST_LOAD;
							end
						end
					end
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mean_calc = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.load_mix = 1'b1;
				set_out = 1'b1;
				state_d = ST_ACCUM;
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACCUM;
			cnt_q     <= CNT_RESET;
			pos_q     <= '0;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
				pos_q <= '0;
			end else if (accept) begin
				pos_q <= is_last ? '0 : POS_W'(pos_cur + (CNT_W+1)'(1));
			end
			if (state_q == ST_DIV) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
			end
			if (set_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/msd_dpath.sv =====
// ----------------------------------------------------------------------------
// msd_dpath
// Datapath: channel holds, rest sum, serial floor divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_dpath #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int SUM_W        = 27
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire msd_pkg::msd_cmd_t         cmd,
	input  wire signed [SAMPLE_WIDTH-1:0]  sample,
	output logic signed [SAMPLE_WIDTH-1:0] left_out,
	output logic signed [SAMPLE_WIDTH-1:0] right_out
);
	import msd_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q, mean_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [SUM_W-1:0]               quo_q;
	logic [CNT_W-1:0]               rem_q;
	logic [CNT_W-1:0]               dvs_q;
	logic                           neg_q;
	logic [CNT_W:0]                 trial;
	logic                           fits;
	logic [SUM_W-1:0]               mean_full;
	logic signed [SAMPLE_WIDTH:0]   lsum, rsum;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_comb begin
		if (neg_q) begin
			mean_full = (~quo_q + SUM_W'(1)) - SUM_W'(rem_q != '0);
		end else begin
			mean_full = quo_q;
		end
	end

	assign lsum = {left_q[SAMPLE_WIDTH-1], left_q} + {mean_q[SAMPLE_WIDTH-1], mean_q};
	assign rsum = {right_q[SAMPLE_WIDTH-1], right_q} + {mean_q[SAMPLE_WIDTH-1], mean_q};

	// holds and rest sum are architectural state, cleared on reset and restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			sum_q   <= '0;
		end else if (cmd.restart) begin
			left_q  <= '0;
			right_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.load_left) begin
				left_q <= sample;
			end
			if (cmd.load_right) begin
				right_q <= sample;
			end
			if (cmd.clear_sum || cmd.load_mix) begin
				sum_q <= '0;
			end else if (cmd.add_rest) begin
				sum_q <= sum_q + SUM_W'(sample);
			end
		end
	end

	// divider on the magnitude, sign fixed up afterwards (floor)
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
		end
		if (cmd.mean_calc) begin
			mean_q <= mean_full[SAMPLE_WIDTH-1:0];
		end
		if (cmd.load_mono) begin
			left_out  <= sample;
			right_out <= sample;
		end else if (cmd.load_pass) begin
			left_out  <= left_q;
			right_out <= sample;
		end else if (cmd.load_mix) begin
			left_out  <= lsum[SAMPLE_WIDTH:1];
			right_out <= rsum[SAMPLE_WIDTH:1];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/multichannel_stereo_downmix.sv =====
// ----------------------------------------------------------------------------
// multichannel_stereo_downmix
// Interleaved multichannel to stereo downmix, signed fixed point.
// ----------------------------------------------------------------------------
// Mid-frame samples are accepted without stall. Mono and stereo: pair
// registered on the frame's last transaction. More than two channels: pair
// registered in ST_EMIT after load, divide, mean (bit-serial divider, one
// quotient bit per cycle, SUM_W = SAMPLE_WIDTH + clog2(MAX_CHANNELS)).
// Reset (async, active low): channel count 2, holds and sum cleared.
`default_nettype none

module multichannel_stereo_downmix #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_WIDTH = 24
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [msd_pkg::CNT_W-1:0]   cfg_wdata,
	msd_sample_if.sink                 samples,
	msd_pair_if.source                 mix
);
	import msd_pkg::*;

	localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_CHANNELS);

	msd_cmd_t cmd;

	msd_ctrl #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SUM_W        (SUM_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (mix.valid),
		.out_ready (mix.ready),
		.cmd       (cmd)
	);

	msd_dpath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_W        (SUM_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (samples.sample),
		.left_out  (mix.left_out),
		.right_out (mix.right_out)
	);

endmodule

`default_nettype wire
